/* src/value_to_color_gradient_core_defines.svh */
// Assertion helpers shared by the gradient core modules.
// Each expects clk and rst_n in scope.
`ifndef VALUE_TO_COLOR_GRADIENT_CORE_DEFINES_SVH
`define VALUE_TO_COLOR_GRADIENT_CORE_DEFINES_SVH

// cond must never hold out of reset
`define VCG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define VCG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define VCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/vcg_pkg.sv */
`default_nettype none

package vcg_pkg;

  localparam int VALUE_W    = 32;
  localparam int CH_W       = 8;
  localparam int NCH        = 4;
  localparam int COLOR_W    = NCH * CH_W;
  localparam int DIV_W      = VALUE_W + CH_W;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LANE_W     = $clog2(NCH);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_COLOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_COLOR = 2'd3;

  // lane order of the back end
  localparam logic [LANE_W-1:0] LANE_RED   = 2'd0;
  localparam logic [LANE_W-1:0] LANE_GREEN = 2'd1;
  localparam logic [LANE_W-1:0] LANE_BLUE  = 2'd2;
  localparam logic [LANE_W-1:0] LANE_ALPHA = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] num;
    logic [VALUE_W-1:0] den;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } qwr_t;

  function automatic logic [CH_W-1:0] lane_byte(input logic [COLOR_W-1:0] color,
                                                input logic [LANE_W-1:0] lane);
    logic [CH_W-1:0] b;
    unique case (lane)
      LANE_RED:   b = color[23:16];
      LANE_GREEN: b = color[15:8];
      LANE_BLUE:  b = color[7:0];
      LANE_ALPHA: b = color[31:24];
      default:    b = color[31:24];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/vcg_front.sv */
`default_nettype none

module vcg_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic signed [vcg_pkg::VALUE_W-1:0] in_sample_value,
  input  wire logic signed [vcg_pkg::VALUE_W-1:0] lower_bound,
  input  wire logic signed [vcg_pkg::VALUE_W-1:0] upper_bound,
  input  wire logic                          q_full,
  output vcg_pkg::qwr_t                      q_wr
);
  import vcg_pkg::*;

  logic                      fr_vld_r, fr_vld_nxt;
  logic signed [VALUE_W-1:0] fr_v_r, fr_v_nxt;
  logic signed [VALUE_W-1:0] fr_lo_r, fr_lo_nxt;
  logic signed [VALUE_W-1:0] fr_hi_r, fr_hi_nxt;
  logic                      fr_go;
  logic                      swap, below, above;
  logic signed [VALUE_W-1:0] lo_s, hi_s;
  logic [VALUE_W:0]          num_w, den_w;
  logic                      bounds_eq;

  // sort the bounds and clamp the sample, all compares in parallel
  always_comb begin
    swap     = upper_bound < lower_bound;
    lo_s     = swap ? upper_bound : lower_bound;
    hi_s     = swap ? lower_bound : upper_bound;
    below    = swap ? (in_sample_value < upper_bound) : (in_sample_value < lower_bound);
    above    = swap ? (in_sample_value > lower_bound) : (in_sample_value > upper_bound);
    fr_v_nxt = below ? lo_s : (above ? hi_s : in_sample_value);
    fr_lo_nxt = lo_s;
    fr_hi_nxt = hi_s;
  end

  // hold the stage while the queue refuses it
  assign fr_go      = !fr_vld_r || !q_full;
  assign in_full    = !fr_go;
  assign fr_vld_nxt = fr_go ? in_push : fr_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_go && in_push) begin
      fr_v_r  <= fr_v_nxt;
      fr_lo_r <= fr_lo_nxt;
      fr_hi_r <= fr_hi_nxt;
    end
  end

  // position as num/den; equal bounds give exactly one half
  always_comb begin
    bounds_eq = fr_hi_r == fr_lo_r;
    num_w     = {fr_v_r[VALUE_W-1], fr_v_r} - {fr_lo_r[VALUE_W-1], fr_lo_r};
    den_w     = {fr_hi_r[VALUE_W-1], fr_hi_r} - {fr_lo_r[VALUE_W-1], fr_lo_r};
    q_wr.vld  = fr_vld_r && !q_full;
    q_wr.item.num = bounds_eq ? VALUE_W'(1) : num_w[VALUE_W-1:0];
    q_wr.item.den = bounds_eq ? VALUE_W'(2) : den_w[VALUE_W-1:0];
  end

endmodule

`default_nettype wire

/* src/vcg_queue.sv */
`default_nettype none

module vcg_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire vcg_pkg::qwr_t  wr,
  output logic                full,
  input  wire logic           rd,
  output logic                empty,
  output vcg_pkg::item_t      rd_item
);
  import vcg_pkg::*;

  `include "value_to_color_gradient_core_defines.svh"

  item_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wp_r, wp_nxt;
  logic [Q_PTR_W-1:0]   rp_r, rp_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr.vld ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr.vld && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr.vld) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.vld) begin
      mem_r[wp_r] <= wr.item;
    end
  end

  `VCG_ASSERT_NEVER(a_q_no_overflow, wr.vld && full, "write into full queue")
  `VCG_ASSERT_NEVER(a_q_no_underflow, rd && empty, "read from empty queue")
  `VCG_ASSERT_NEXT(a_q_count_up, wr.vld && !rd, cnt_r == Q_CNT_W'($past(cnt_r) + 1'b1), "count did not advance")

endmodule

`default_nettype wire

/* src/vcg_back.sv */
`default_nettype none

module vcg_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  output logic                             q_rd,
  input  wire vcg_pkg::item_t              q_item,
  input  wire logic [vcg_pkg::COLOR_W-1:0] lower_color,
  input  wire logic [vcg_pkg::COLOR_W-1:0] upper_color,
  input  wire logic                        out_pop,
  output logic                             out_empty,
  output logic [vcg_pkg::CH_W-1:0]         out_red_out,
  output logic [vcg_pkg::CH_W-1:0]         out_green_out,
  output logic [vcg_pkg::CH_W-1:0]         out_blue_out,
  output logic [vcg_pkg::CH_W-1:0]         out_alpha_out
);
  import vcg_pkg::*;

  `include "value_to_color_gradient_core_defines.svh"

  // stage 0 multiplies, stages 1..CH_W each resolve one quotient bit
  logic [CH_W:0]        vld_r, vld_nxt;
  logic [VALUE_W-1:0]   den_r   [CH_W+1];
  logic [VALUE_W-1:0]   den_nxt [CH_W+1];
  logic [DIV_W-1:0]     rem_r   [CH_W+1][NCH];
  logic [DIV_W-1:0]     rem_nxt [CH_W+1][NCH];
  logic [CH_W-1:0]      quo_r   [CH_W+1][NCH];
  logic [CH_W-1:0]      quo_nxt [CH_W+1][NCH];
  logic [DIV_W:0]       trial   [CH_W+1][NCH];
  logic                 out_vld_r;
  logic [CH_W-1:0]      out_res_r   [NCH];
  logic [CH_W-1:0]      out_res_nxt [NCH];
  logic [CH_W-1:0]      lo_c [NCH];
  logic [CH_W-1:0]      hi_c [NCH];
  logic [CH_W-1:0]      dabs [NCH];
  logic                 neg  [NCH];
  logic [VALUE_W:0]     twice_r [NCH];
  logic                 rnd  [NCH];
  logic [CH_W-1:0]      mag  [NCH];
  logic                 en;

  assign en        = !out_vld_r || out_pop;
  assign q_rd      = en && !q_empty;
  assign out_empty = !out_vld_r;

  always_comb begin
    for (int l = 0; l < NCH; l++) begin
      lo_c[l] = lane_byte(lower_color, LANE_W'(l));
      hi_c[l] = lane_byte(upper_color, LANE_W'(l));
      neg[l]  = hi_c[l] < lo_c[l];
      dabs[l] = neg[l] ? lo_c[l] - hi_c[l] : hi_c[l] - lo_c[l];
    end
  end

  always_comb begin
    vld_nxt[0] = q_rd;
    den_nxt[0] = q_item.den;
    for (int l = 0; l < NCH; l++) begin
      rem_nxt[0][l] = DIV_W'(dabs[l]) * DIV_W'(q_item.num);
      quo_nxt[0][l] = '0;
      trial[0][l]   = '0;
    end
    for (int k = 1; k <= CH_W; k++) begin
      vld_nxt[k] = vld_r[k-1];
      den_nxt[k] = den_r[k-1];
      for (int l = 0; l < NCH; l++) begin
        trial[k][l] = {1'b0, rem_r[k-1][l]}
                    - ({1'b0, DIV_W'(den_r[k-1])} << (CH_W - k));
        quo_nxt[k][l] = quo_r[k-1][l];
        quo_nxt[k][l][CH_W-k] = !trial[k][l][DIV_W];
        rem_nxt[k][l] = trial[k][l][DIV_W] ? rem_r[k-1][l] : trial[k][l][DIV_W-1:0];
      end
    end
  end

  // round half up: add one on a positive slope when 2r >= den,
  // subtract one more on a negative slope when 2r > den
  always_comb begin
    for (int l = 0; l < NCH; l++) begin
      twice_r[l] = {rem_r[CH_W][l][VALUE_W-1:0], 1'b0};
      rnd[l]     = neg[l] ? (twice_r[l] > {1'b0, den_r[CH_W]})
                          : (twice_r[l] >= {1'b0, den_r[CH_W]});
      mag[l]     = quo_r[CH_W][l] + CH_W'(rnd[l]);
      out_res_nxt[l] = neg[l] ? lo_c[l] - mag[l] : lo_c[l] + mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= vld_nxt;
      out_vld_r <= vld_r[CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r     <= den_nxt;
      rem_r     <= rem_nxt;
      quo_r     <= quo_nxt;
      out_res_r <= out_res_nxt;
    end
  end

  assign out_red_out   = out_res_r[LANE_RED];
  assign out_green_out = out_res_r[LANE_GREEN];
  assign out_blue_out  = out_res_r[LANE_BLUE];
  assign out_alpha_out = out_res_r[LANE_ALPHA];

  `VCG_ASSERT_IMPL(a_rem_below_den, vld_r[CH_W], rem_r[CH_W][0] < DIV_W'(den_r[CH_W]), "remainder not reduced")
  `VCG_ASSERT_IMPL(a_quo_in_range, vld_r[CH_W], quo_r[CH_W][0] <= dabs[0], "quotient exceeds channel span")
  `VCG_ASSERT_NEXT(a_out_load, en && vld_r[CH_W], out_vld_r, "finished item not loaded to output")

endmodule

`default_nettype wire

/* src/value_to_color_gradient_core.sv */
// Pipeline: one clamp stage, the queue write, a multiply stage, eight divide stages
//   and the rounding output register.
// Throughput: one item per cycle while results are popped (a held result stalls the back end
//   and, once the queue fills, the input); each divide stage resolves one quotient bit for all four channels at once.
// Reset: synchronous, active low; empties the pipeline and queue, clears the config registers to 0.
`default_nettype none

module value_to_color_gradient_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic signed [vcg_pkg::VALUE_W-1:0] in_sample_value,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic [vcg_pkg::CH_W-1:0]              out_red_out,
  output logic [vcg_pkg::CH_W-1:0]              out_green_out,
  output logic [vcg_pkg::CH_W-1:0]              out_blue_out,
  output logic [vcg_pkg::CH_W-1:0]              out_alpha_out,
  input  wire logic                             cfg_we,
  input  wire logic [vcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vcg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vcg_pkg::*;

  logic signed [VALUE_W-1:0] lower_bound_r, upper_bound_r;
  logic [COLOR_W-1:0]        lower_color_r, upper_color_r;
  qwr_t                      q_wr;
  logic                      q_full, q_empty, q_rd;
  item_t                     q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r <= '0;
      upper_bound_r <= '0;
      lower_color_r <= '0;
      upper_color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOWER_BOUND: lower_bound_r <= VALUE_W'(cfg_wdata);
        REG_UPPER_BOUND: upper_bound_r <= VALUE_W'(cfg_wdata);
        REG_LOWER_COLOR: lower_color_r <= COLOR_W'(cfg_wdata);
        REG_UPPER_COLOR: upper_color_r <= COLOR_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  vcg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_value (in_sample_value),
    .lower_bound     (lower_bound_r),
    .upper_bound     (upper_bound_r),
    .q_full          (q_full),
    .q_wr            (q_wr)
  );

  vcg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .full    (q_full),
    .rd      (q_rd),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  vcg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_rd          (q_rd),
    .q_item        (q_item),
    .lower_color   (lower_color_r),
    .upper_color   (upper_color_r),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_alpha_out (out_alpha_out)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vcg_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 15;
  localparam int PHASE_COUNT = 16;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic signed [VALUE_W-1:0] in_sample_value;
  logic out_empty;
  logic out_pop;
  logic [CH_W-1:0] out_red_out;
  logic [CH_W-1:0] out_green_out;
  logic [CH_W-1:0] out_blue_out;
  logic [CH_W-1:0] out_alpha_out;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // shadow copies of the block's registers
  logic signed [VALUE_W-1:0] bound_lo_q;
  logic signed [VALUE_W-1:0] bound_hi_q;
  logic [COLOR_W-1:0] color_lo_q;
  logic [COLOR_W-1:0] color_hi_q;

  rgba_t expected_colors[$];
  int error_count;
  int cycle_count;
  bit steady;

  value_to_color_gradient_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_value (in_sample_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_alpha_out   (out_alpha_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // lower + floor(delta * num / den + 1/2), exact in integers
  function automatic logic [CH_W-1:0] blend_lane(logic [CH_W-1:0] lo_c, logic [CH_W-1:0] hi_c,
                                                 longint num, longint den);
    longint delta;
    longint n;
    longint d;
    longint q;
    delta = longint'(hi_c) - longint'(lo_c);
    n = 2 * delta * num + den;
    d = 2 * den;
    if (n >= 0) begin
      q = n / d;
    end else begin
      q = -((-n + d - 1) / d);
    end
    return CH_W'(longint'(lo_c) + q);
  endfunction

  function automatic rgba_t predict_color(logic signed [VALUE_W-1:0] sample);
    longint lo;
    longint hi;
    longint v;
    longint t;
    longint num;
    longint den;
    rgba_t c;
    lo = longint'(bound_lo_q);
    hi = longint'(bound_hi_q);
    v = longint'(sample);
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (hi == lo) begin
      num = 1;
      den = 2;
    end else begin
      num = v - lo;
      den = hi - lo;
    end
    c.red   = blend_lane(color_lo_q[23:16], color_hi_q[23:16], num, den);
    c.green = blend_lane(color_lo_q[15:8], color_hi_q[15:8], num, den);
    c.blue  = blend_lane(color_lo_q[7:0], color_hi_q[7:0], num, den);
    c.alpha = blend_lane(color_lo_q[31:24], color_hi_q[31:24], num, den);
    return c;
  endfunction

  function automatic void check_lane(string lane_name, logic [CH_W-1:0] want,
                                     logic [CH_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, lane_name, want, got);
      error_count++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly in bounds, some at and around the bounds, some anywhere
  function automatic logic [VALUE_W-1:0] pick_sample();
    longint lo;
    longint hi;
    longint t;
    longint unsigned span;
    int r;
    lo = longint'(bound_lo_q);
    hi = longint'(bound_hi_q);
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    r = $urandom_range(0, 9);
    case (r)
      0, 1: return $urandom;
      2: return VALUE_W'(lo - longint'($urandom_range(1, 3)));
      3: return VALUE_W'(hi + longint'($urandom_range(0, 3)));
      4: return VALUE_W'(lo + longint'($urandom_range(0, 3)));
      default: begin
        span = longint'(hi - lo + 1);
        return VALUE_W'(lo + longint'({$urandom, $urandom} % span));
      end
    endcase
  endfunction

  // track accepted samples and check every result transfer
  always @(posedge clk) begin
    rgba_t want;
    if (rst_n) begin
      if (in_push && !in_full) expected_colors.push_back(predict_color(in_sample_value));
      if (out_pop && !out_empty) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h %0h %0h %0h", $time,
                   out_red_out, out_green_out, out_blue_out, out_alpha_out);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          check_lane("red", want.red, out_red_out);
          check_lane("green", want.green, out_green_out);
          check_lane("blue", want.blue, out_blue_out);
          check_lane("alpha", want.alpha, out_alpha_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, a few of them long
  initial begin
    int stall;
    int r;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_pop = 1'b1;
      end else if (stall > 0) begin
        out_pop = 1'b0;
        stall--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_pop = 1'b1;
        end else begin
          out_pop = 1'b0;
          stall = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      REG_LOWER_BOUND: bound_lo_q = data;
      REG_UPPER_BOUND: bound_hi_q = data;
      REG_LOWER_COLOR: color_lo_q = data;
      REG_UPPER_COLOR: color_hi_q = data;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [31:0] lb, logic [31:0] ub, logic [31:0] lc,
                             logic [31:0] uc);
    write_reg(REG_LOWER_BOUND, lb);
    write_reg(REG_UPPER_BOUND, ub);
    write_reg(REG_LOWER_COLOR, lc);
    write_reg(REG_UPPER_COLOR, uc);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_sample(logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_push = 1'b0;
    end
    @(negedge clk);
    in_push = 1'b1;
    in_sample_value = v;
    do @(posedge clk); while (in_full);
  endtask

  // drop push and hold until every result has been transferred
  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh0000_0000);
    drain();
  endtask

  task automatic test_ordered_bounds();
    load_config(-32'sd100, 32'sd100, 32'h0000_0000, 32'hffff_ffff);
    steady = 1'b1;
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(-32'sd100);
    send_sample(32'sd100);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    send_sample(32'sd50);
    steady = 1'b0;
    drain();
  endtask

  task automatic test_reversed_bounds();
    // colors stay where they are when the bounds swap
    load_config(32'sd1000, -32'sd1000, 32'h1020_4080, 32'hf0e0_c0a1);
    send_sample(-32'sd1000);
    send_sample(32'sd1000);
    send_sample(32'sd0);
    send_sample(32'sd1234);
    send_sample(-32'sd999);
    drain();
  endtask

  task automatic test_equal_bounds();
    // odd deltas of both signs land on the half point
    load_config(32'sd7, 32'sd7, 32'hff00_ff01, 32'h00ff_00fe);
    send_sample(32'sd7);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    drain();
  endtask

  task automatic test_full_range();
    load_config(32'h8000_0000, 32'h7fff_ffff, 32'h00ff_00ff, 32'hff00_ff00);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sh4000_0000);
    drain();
  endtask

  task automatic test_random_phases();
    int kind;
    int rc;
    logic [31:0] lb;
    logic [31:0] ub;
    logic [31:0] lc;
    logic [31:0] uc;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      kind = (phase < 6) ? phase : $urandom_range(0, 5);
      lb = $urandom;
      case (kind)
        0: ub = $urandom;
        1: ub = lb + $urandom_range(1, 12);
        2: ub = lb;
        3: begin
          lb = 32'h8000_0000;
          ub = 32'h7fff_ffff;
          if ($urandom_range(0, 1) == 1) begin
            lb = 32'h7fff_ffff;
            ub = 32'h8000_0000;
          end
        end
        4: ub = lb - $urandom_range(1, 12);
        default: ub = lb + $urandom_range(1, 100000);
      endcase
      rc = $urandom_range(0, 3);
      lc = (rc == 0) ? 32'h0000_0000 : (rc == 1) ? 32'hffff_ffff : $urandom;
      uc = (rc == 0) ? 32'hffff_ffff : (rc == 1) ? 32'h0000_0000 : $urandom;
      load_config(lb, ub, lc, uc);
      steady = (phase == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 3 && i == PHASE_ITEMS / 2) drain();
        send_sample(pick_sample());
      end
      steady = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_sample_value = '0;
    cfg_we = 1'b0;
    cfg_index = REG_LOWER_BOUND;
    cfg_wdata = '0;
    bound_lo_q = '0;
    bound_hi_q = '0;
    color_lo_q = '0;
    color_hi_q = '0;
    error_count = 0;
    cycle_count = 0;
    steady = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_ordered_bounds();
    test_reversed_bounds();
    test_equal_bounds();
    test_full_range();
    test_random_phases();

    if (expected_colors.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_colors.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
